// File: sv/bpc_pkg.sv
package bpc_pkg;

	localparam int TIME_W = 32;
	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam logic [1:0] CLICK_MAX = 2'd3;

	typedef enum logic [2:0] {
		EV_NONE    = 3'd0,
		EV_PRESSED = 3'd1,
		EV_SHORT   = 3'd2,
		EV_LONG    = 3'd3,
		EV_VLONG   = 3'd4,
		EV_DOUBLE  = 3'd5,
		EV_TRIPLE  = 3'd6
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 3'd0,
		REG_SHORT    = 3'd1,
		REG_LONG     = 3'd2,
		REG_VLONG    = 3'd3,
		REG_WINDOW   = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [CFG_W-1:0] debounce_ms;
		logic [CFG_W-1:0] short_press_ms;
		logic [CFG_W-1:0] long_press_ms;
		logic [CFG_W-1:0] very_long_press_ms;
		logic [CFG_W-1:0] multi_click_window_ms;
	} cfg_t;

	// Result of one sample as the core hands it to the result register.
	typedef struct packed {
		event_t event_res;
		logic   stable_pressed;
	} result_t;

	function automatic logic [TIME_W-1:0] ext_ms(input logic [CFG_W-1:0] ms);
		return {{(TIME_W-CFG_W){1'b0}}, ms};
	endfunction

endpackage

// File: sv/bpc_in_if.sv
interface bpc_in_if
	import bpc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              pin_level;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, output pin_level, output time_ms, input ready);
	modport sink (input valid, input pin_level, input time_ms, output ready);
endinterface

// File: sv/bpc_out_if.sv
interface bpc_out_if;
	logic       valid;
	logic       ready;
	logic [2:0] event_res;
	logic       stable_pressed;

	modport source (output valid, output event_res, output stable_pressed, input ready);
	modport sink (input valid, input event_res, input stable_pressed, output ready);
endinterface

// File: sv/bpc_cfg_if.sv
interface bpc_cfg_if
	import bpc_pkg::*;
();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/button_press_classifier.sv
// Debounces an active-low button pin sampled with a millisecond timestamp and
// gives exactly one result per sample: an event code (none, pressed, short,
// long or very long press, double or triple click) and the debounced level.
// One sample is taken every clock cycle unless the input stalls; the result
// of an accepted request is held in the input register, then sits in the
// result register until it is taken, with the classification done by the
// subtract-and-compare logic in between.
// Backpressure on the result side stalls the input only once both registers
// are full. Configuration writes take effect at once and are meant for idle
// periods; writes to an index above four are ignored.
module button_press_classifier
	import bpc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	bpc_in_if.sink   samples,
	bpc_out_if.source results,
	bpc_cfg_if.sink  cfg
);

	cfg_t              cfg_q;
	result_t           result;
	logic              valid_s1;
	logic              pin_s1;
	logic [TIME_W-1:0] time_s1;
	logic              res_valid_q;
	event_t            event_q;
	logic              stable_q;
	logic              advance;

	bpc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.cfg_q  (cfg_q)
	);

	assign advance       = valid_s1 && (!res_valid_q || results.ready);
	assign samples.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.ready && samples.valid) begin
			pin_s1  <= samples.pin_level;
			time_s1 <= samples.time_ms;
		end
	end

	bpc_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.advance   (advance),
		.pin_level (pin_s1),
		.time_ms   (time_s1),
		.result    (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (results.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_q  <= result.event_res;
			stable_q <= result.stable_pressed;
		end
	end

	assign results.valid          = res_valid_q;
	assign results.event_res      = event_q;
	assign results.stable_pressed = stable_q;

`ifndef ASSERT_OFF
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("input stage dropped a stalled request");

	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> res_valid_q)
		else $error("processed request did not reach the result register");

	a_pressed_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && event_q == EV_PRESSED |-> stable_q)
		else $error("pressed event with released debounced level");

	a_release_level: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && (event_q == EV_SHORT || event_q == EV_LONG || event_q == EV_VLONG)
		|-> !stable_q)
		else $error("release event with pressed debounced level");
`endif

endmodule

// File: sv/bpc_cfg_regs.sv
module bpc_cfg_regs
	import bpc_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	bpc_cfg_if.sink   cfg,
	output cfg_t      cfg_q
);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms           <= CFG_W'(50);
			cfg_q.short_press_ms        <= CFG_W'(50);
			cfg_q.long_press_ms         <= CFG_W'(1000);
			cfg_q.very_long_press_ms    <= CFG_W'(3000);
			cfg_q.multi_click_window_ms <= CFG_W'(400);
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_DEBOUNCE: cfg_q.debounce_ms           <= cfg.data;
				REG_SHORT:    cfg_q.short_press_ms        <= cfg.data;
				REG_LONG:     cfg_q.long_press_ms         <= cfg.data;
				REG_VLONG:    cfg_q.very_long_press_ms    <= cfg.data;
				REG_WINDOW:   cfg_q.multi_click_window_ms <= cfg.data;
				default: ;
			endcase
		end
	end

endmodule

// File: sv/bpc_core.sv
module bpc_core
	import bpc_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              advance,
	input  logic              pin_level,
	input  logic [TIME_W-1:0] time_ms,
	output result_t           result
);

	logic              prev_raw_q;
	logic              debounced_q;
	logic [TIME_W-1:0] change_stamp_q;
	logic [TIME_W-1:0] press_stamp_q;
	logic [1:0]        click_tally_q;

	logic              raw;
	logic              raw_changed;
	logic [TIME_W-1:0] steady_time;
	logic [TIME_W-1:0] held_time;
	logic [TIME_W-1:0] window_time;
	logic              settled;
	logic              press_ev;
	logic              release_ev;
	logic              expired;
	logic [1:0]        tally_inc;
	logic [1:0]        tally_n;
	logic              debounced_n;
	event_t            hold_ev;
	event_t            event_n;

	assign raw         = ~pin_level;
	assign raw_changed = raw != prev_raw_q;

	// A raw change restamps, so the steady time of this sample is then zero.
	assign steady_time = raw_changed ? '0 : time_ms - change_stamp_q;
	assign settled     = steady_time > ext_ms(cfg.debounce_ms);
	assign press_ev    = settled && raw && !debounced_q;
	assign release_ev  = settled && !raw && debounced_q;
	assign debounced_n = settled ? raw : debounced_q;

	assign held_time = time_ms - press_stamp_q;

	always_comb begin
		if (held_time >= ext_ms(cfg.very_long_press_ms)) begin
			hold_ev = EV_VLONG;
		end else if (held_time >= ext_ms(cfg.long_press_ms)) begin
			hold_ev = EV_LONG;
		end else if (held_time >= ext_ms(cfg.short_press_ms)) begin
			hold_ev = EV_SHORT;
		end else begin
			hold_ev = EV_NONE;
		end
	end

	assign tally_inc = (press_ev && click_tally_q != CLICK_MAX) ? click_tally_q + 2'd1
		: click_tally_q;

	// A press in this sample restarts the window at zero.
	assign window_time = press_ev ? '0 : held_time;
	assign expired     = (tally_inc != 2'd0)
		&& (window_time > ext_ms(cfg.multi_click_window_ms));
	assign tally_n     = expired ? 2'd0 : tally_inc;

	always_comb begin
		if (press_ev) begin
			event_n = EV_PRESSED;
		end else if (release_ev) begin
			event_n = hold_ev;
		end else begin
			event_n = EV_NONE;
		end
		// A multi-click decision overrides the press or release event.
		if (expired && tally_inc == CLICK_MAX) begin
			event_n = EV_TRIPLE;
		end else if (expired && tally_inc == 2'd2) begin
			event_n = EV_DOUBLE;
		end
	end

	assign result.event_res      = event_n;
	assign result.stable_pressed = debounced_n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_raw_q     <= 1'b0;
			debounced_q    <= 1'b0;
			change_stamp_q <= '0;
			press_stamp_q  <= '0;
			click_tally_q  <= 2'd0;
		end else if (advance) begin
			prev_raw_q    <= raw;
			debounced_q   <= debounced_n;
			click_tally_q <= tally_n;
			if (raw_changed) begin
				change_stamp_q <= time_ms;
			end
			if (press_ev) begin
				press_stamp_q <= time_ms;
			end
		end
	end

endmodule
